[hdl/tqs_pkg.sv]
// ----------------------------------------------------------------------------
// Timer queue scheduler package
// Shared widths, codes and helper types for the timer queue scheduler.
// ----------------------------------------------------------------------------
package tqs_pkg;

    localparam int MaxTimers = 32;
    localparam int IdW       = 5;
    localparam int CntW      = 6;
    localparam int TimeW     = 48;
    localparam int IntW      = 32;
    localparam int CtxW      = 32;

    localparam logic [1:0] MODE_SCHED  = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_SUMM   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic             status;
        logic [IdW-1:0]   id;
        logic [CtxW-1:0]  ctx;
        logic [CntW-1:0]  cnt;
        logic             empty;
        logic [TimeW-1:0] wait_t;
        logic             last;
    } result_t;

endpackage

[hdl/timer_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// Timer queue scheduler
// Up to 32 timers held in slot memories, free ids in a FIFO memory.
// ----------------------------------------------------------------------------
// After reset the free id list is filled, with in_ready low. A schedule
// reply is offered once the S_SCHED state has taken a free id; a cancel
// reply, or a schedule reply when no id is free, is offered in the cycle
// after its transfer. An expire walks all 32 slots (one memory read a cycle)
// once per due timer and once more for the summary. A fired timer passes
// the hand-off, fire and output states; a dropped cancelled timer passes
// only the hand-off and fire states. Each result waits in an output
// register until it is taken, and no new transfer is accepted until the
// last result of the current one has gone.
module timer_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [47:0] first_deadline,
    input  logic [31:0] repeat_interval,
    input  logic [31:0] context_tag,
    input  logic [4:0]  timer_id,
    input  logic [47:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        status,
    output logic [4:0]  timer_id_out,
    output logic [31:0] context_out,
    output logic [5:0]  fired_count,
    output logic        queue_empty,
    output logic [47:0] wait_ticks,
    output logic        last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCHED = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_HAND  = 3'd3;
    localparam logic [2:0] S_FIRE  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int IdW   = tqs_pkg::IdW;
    localparam int TimeW = tqs_pkg::TimeW;
    localparam logic [TimeW-1:0] TMax = '1;

    // slot memory: deadline, interval, context
    logic [TimeW-1:0]         dl_mem  [tqs_pkg::MaxTimers];
    logic [tqs_pkg::IntW-1:0] iv_mem  [tqs_pkg::MaxTimers];
    logic [tqs_pkg::CtxW-1:0] ctx_mem [tqs_pkg::MaxTimers];
    logic [IdW-1:0]           fifo_mem[tqs_pkg::MaxTimers];

    logic [tqs_pkg::MaxTimers-1:0] pend_reg, canc_reg, done_reg;
    logic [IdW-1:0]  head_reg;
    logic [IdW:0]    fcnt_reg;
    logic [IdW:0]    init_reg;
    logic [2:0]      state_reg;
    logic [TimeW-1:0] now_reg, dl_in_reg;
    logic [31:0]     iv_in_reg, ctx_in_reg;
    logic [IdW:0]    scan_reg;
    logic            rd_v_reg;
    logic [IdW-1:0]  rd_a_reg;
    logic [TimeW-1:0] dl_q, best_reg, bestall_reg;
    logic [31:0]     iv_q, ctx_q;
    logic [IdW-1:0]  fifo_q, sel_reg;
    logic            sel_v_reg, any_reg;
    logic [tqs_pkg::CntW-1:0] fired_reg;
    logic            ov_reg;
    tqs_pkg::result_t res_reg;

    // memory write port, shared
    logic            wr_en;
    logic [IdW-1:0]  wr_a;
    logic [TimeW-1:0] wr_dl;
    logic            wr_all;
    logic            fw_en;
    logic [IdW-1:0]  fw_a, fw_d;
    logic [IdW-1:0]  rd_a;
    logic [TimeW-1:0] rearm;
    logic [TimeW:0]  rsum;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dl_mem[wr_a] <= wr_dl;
            if (wr_all)
            begin
                iv_mem[wr_a]  <= iv_in_reg;
                ctx_mem[wr_a] <= ctx_in_reg;
            end
        end
        if (fw_en)
        begin
            fifo_mem[fw_a] <= fw_d;
        end
        dl_q   <= dl_mem[rd_a];
        iv_q   <= iv_mem[rd_a];
        ctx_q  <= ctx_mem[rd_a];
        fifo_q <= fifo_mem[head_reg];
    end

    assign rd_a = (state_reg == S_HAND) ? sel_reg : scan_reg[IdW-1:0];
    assign rsum = {1'b0, now_reg} + {{(TimeW-32+1){1'b0}}, iv_q};
    assign rearm = rsum[TimeW] ? TMax : rsum[TimeW-1:0];

    assign in_ready = (state_reg == S_IDLE) && !out_valid && !init_reg[IdW];
    assign out_valid = (state_reg == S_OUT) || (res_reg.last && ov_reg);

    logic due;
    assign due = rd_v_reg && pend_reg[rd_a_reg] && !done_reg[rd_a_reg]
                 && (dl_q <= now_reg);

    always_comb
    begin
        wr_en  = 1'b0;
        wr_a   = head_reg;
        wr_dl  = dl_in_reg;
        wr_all = 1'b0;
        fw_en  = 1'b0;
        fw_a   = init_reg[IdW-1:0];
        fw_d   = init_reg[IdW-1:0];
        if (init_reg[IdW])
        begin
            fw_en = 1'b1;
        end
        else if (state_reg == S_SCHED)
        begin
            wr_en  = 1'b1;
            wr_a   = fifo_q;
            wr_all = 1'b1;
        end
        else if (state_reg == S_FIRE)
        begin
            if (!canc_reg[sel_reg] && iv_q != '0)
            begin
                wr_en = 1'b1;
                wr_a  = sel_reg;
                wr_dl = rearm;
            end
            else
            begin
                fw_en = 1'b1;
                fw_a  = head_reg + fcnt_reg[IdW-1:0];
                fw_d  = sel_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= '0;
            canc_reg  <= '0;
            done_reg  <= '0;
            head_reg  <= '0;
            fcnt_reg  <= 6'd32;
            init_reg  <= {1'b1, {IdW{1'b0}}};
            ov_reg    <= 1'b0;
            rd_v_reg  <= 1'b0;
            scan_reg  <= '0;
            sel_v_reg <= 1'b0;
            any_reg   <= 1'b0;
            fired_reg <= '0;
        end
        else
        begin
            if (init_reg[IdW])
            begin
                init_reg <= (init_reg[IdW-1:0] == '1) ? '0 : init_reg + 1'b1;
            end
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        dl_in_reg  <= first_deadline;
                        iv_in_reg  <= repeat_interval;
                        ctx_in_reg <= context_tag;
                        now_reg    <= now_time;
                        unique case (mode)
                            tqs_pkg::MODE_SCHED:
                            begin
                                res_reg <= '{kind: tqs_pkg::KIND_SCHED,
                                             status: (fcnt_reg == '0),
                                             last: 1'b1, default: '0};
                                if (fcnt_reg == '0)
                                begin
                                    ov_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_SCHED;
                                end
                            end
                            tqs_pkg::MODE_CANCEL:
                            begin
                                res_reg <= '{kind: tqs_pkg::KIND_CANCEL,
                                             last: 1'b1, default: '0};
                                if (pend_reg[timer_id])
                                begin
                                    canc_reg[timer_id] <= 1'b1;
                                end
                                ov_reg <= 1'b1;
                            end
                            tqs_pkg::MODE_EXPIRE:
                            begin
                                done_reg  <= '0;
                                fired_reg <= '0;
                                scan_reg  <= '0;
                                rd_v_reg  <= 1'b0;
                                sel_v_reg <= 1'b0;
                                any_reg   <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCHED:
                begin
                    pend_reg[fifo_q] <= 1'b1;
                    canc_reg[fifo_q] <= 1'b0;
                    head_reg <= head_reg + 1'b1;
                    fcnt_reg <= fcnt_reg - 1'b1;
                    res_reg.id <= fifo_q;
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    rd_v_reg <= !scan_reg[IdW];
                    rd_a_reg <= scan_reg[IdW-1:0];
                    if (!scan_reg[IdW])
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (due && (!sel_v_reg || dl_q < best_reg))
                    begin
                        sel_v_reg <= 1'b1;
                        sel_reg   <= rd_a_reg;
                        best_reg  <= dl_q;
                    end
                    if (rd_v_reg && pend_reg[rd_a_reg]
                        && (!any_reg || dl_q < bestall_reg))
                    begin
                        any_reg     <= 1'b1;
                        bestall_reg <= dl_q;
                    end
                    if (scan_reg[IdW] && !rd_v_reg)
                    begin
                        if (sel_v_reg || due)
                        begin
                            state_reg <= S_HAND;
                        end
                        else
                        begin
                            res_reg <= '{kind: tqs_pkg::KIND_SUMM,
                                         cnt: fired_reg,
                                         empty: !any_reg,
                                         wait_t: !any_reg ? TMax :
                                             ((bestall_reg > now_reg) ?
                                              bestall_reg - now_reg : '0),
                                         last: 1'b1,
                                         default: '0};
                            ov_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_HAND:
                begin
                    done_reg[sel_reg] <= 1'b1;
                    state_reg <= S_FIRE;
                end
                S_FIRE:
                begin
                    if (canc_reg[sel_reg] || iv_q == '0)
                    begin
                        pend_reg[sel_reg] <= 1'b0;
                        canc_reg[sel_reg] <= 1'b0;
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end
                    scan_reg  <= '0;
                    rd_v_reg  <= 1'b0;
                    sel_v_reg <= 1'b0;
                    any_reg   <= 1'b0;
                    if (canc_reg[sel_reg])
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        res_reg <= '{kind: tqs_pkg::KIND_FIRE, id: sel_reg,
                                     ctx: ctx_q, default: '0};
                        fired_reg <= fired_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign kind         = res_reg.kind;
    assign status       = res_reg.status;
    assign timer_id_out = res_reg.id;
    assign context_out  = res_reg.ctx;
    assign fired_count  = res_reg.cnt;
    assign queue_empty  = res_reg.empty;
    assign wait_ticks   = res_reg.wait_t;
    assign last         = res_reg.last;

endmodule
